### sv/vandermonde_coded_fragment_unit_defines.svh
// assertion macros for the coded fragment unit
// used by modules that name aclk and aresetn; no other dependencies
`ifndef VANDERMONDE_CODED_FRAGMENT_UNIT_DEFINES_SVH
`define VANDERMONDE_CODED_FRAGMENT_UNIT_DEFINES_SVH

// same-cycle implication, off while in reset
`define VCF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define VCF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/vcf_pkg.sv
// widths, constants and the stored state record of the coded fragment unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vcf_pkg;

    localparam int DATA_W     = 8;
    localparam int WORD_W     = 15;
    localparam int GRP_W      = 9;
    localparam int LEN_W      = 32;
    localparam int POINT_W    = WORD_W + 1;
    localparam int SUM_W      = WORD_W + DATA_W + 1;
    localparam int PROD_W     = 2 * WORD_W;
    localparam int RED_STEPS  = PROD_W;
    localparam int STEP_W     = $clog2(RED_STEPS);
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam int MAX_GROUP  = 256;
    localparam logic [DATA_W-1:0] PAD_BYTE = 8'd48;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_REPLICA_INDEX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_SIZE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS       = 2'd2;

    localparam logic [WORD_W-1:0] RST_REPLICA_INDEX = 15'd0;
    localparam logic [GRP_W-1:0]  RST_GROUP_SIZE    = 9'd1;
    localparam logic [WORD_W-1:0] RST_MODULUS       = 15'd257;

    // one word of the state memory
    typedef struct packed {
        logic [LEN_W-1:0]  byte_count;
        logic [WORD_W-1:0] current_power;
        logic [GRP_W-1:0]  group_position;
        logic [WORD_W-1:0] group_accumulator;
    } fold_state_t;

    localparam fold_state_t FOLD_STATE_RESET = '{
        byte_count:        '0,
        current_power:     WORD_W'(1),
        group_position:    '0,
        group_accumulator: '0
    };

    // one restoring remainder step: shift in a bit, subtract the modulus if it fits
    function automatic logic [WORD_W-1:0] rem_step(
        input logic [WORD_W-1:0] rem,
        input logic              bit_in,
        input logic [WORD_W-1:0] modv
    );
        logic [WORD_W:0] trial;
        trial = {rem, bit_in};
        if (trial >= {1'b0, modv}) begin
            trial = trial - {1'b0, modv};
        end
        return trial[WORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

### sv/vandermonde_coded_fragment_unit.sv
// coded fragment unit: one byte in, folded into a mod-m weighted group sum
// each byte goes through read, multiply, the 30-step remainder loop and done; done
// registers a due word, waiting while the output is held; a new byte is taken only in
// idle, and a short final group adds a multiply and remainder pass per pad byte
// reset: synchronous, active low; control and configuration registers take their reset
// values and the state word reads as reset until first written
`timescale 1ns / 1ps
`default_nettype none
`include "vandermonde_coded_fragment_unit_defines.svh"

module vandermonde_coded_fragment_unit
    import vcf_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // byte requests
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  wire logic                  s_tlast,   // end_of_message
    // coded words
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [14:0] coded_word, [46:15] unpadded_len
    output logic                       m_tlast    // final_word
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_RED,
        ST_DONE
    } fsm_t;

    fsm_t state_reg, state_next;

    logic [WORD_W-1:0] replica_index_reg, replica_index_next;
    logic [GRP_W-1:0]  group_size_reg,    group_size_next;
    logic [WORD_W-1:0] modulus_reg,       modulus_next;

    logic [WORD_W-1:0] acc_reg,  acc_next;
    logic [WORD_W-1:0] pow_reg,  pow_next;
    logic [GRP_W-1:0]  pos_reg,  pos_next;
    logic [LEN_W-1:0]  cnt_reg,  cnt_next;
    logic [DATA_W-1:0] byte_reg, byte_next;
    logic              last_reg, last_next;
    logic              pad_reg,  pad_next;

    logic [PROD_W-1:0] num_acc_reg, num_acc_next;
    logic [PROD_W-1:0] num_pow_reg, num_pow_next;
    logic [WORD_W-1:0] rem_acc_reg, rem_acc_next;
    logic [WORD_W-1:0] rem_pow_reg, rem_pow_next;
    logic [STEP_W-1:0] step_reg,    step_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic              m_tlast_reg,  m_tlast_next;
    logic [WORD_W-1:0] word_reg,     word_next;
    logic [LEN_W-1:0]  len_reg,      len_next;

    // state memory, one word, registered read
    fold_state_t state_mem [0:0];
    fold_state_t rd_data_reg;
    fold_state_t wr_data;
    logic        rd_en;
    logic        wr_en;
    logic        mem_vld_reg, mem_vld_next;
    fold_state_t cur_state;

    logic [WORD_W-1:0] eff_mod;
    logic [GRP_W-1:0]  eff_group;
    logic [GRP_W-1:0]  pos_inc;
    logic [SUM_W-1:0]  sum_val;
    logic [POINT_W-1:0] point;
    logic [PROD_W-1:0] prod_val;
    logic              emit;

    assign eff_mod = (modulus_reg == '0) ? WORD_W'(1) : modulus_reg;

    always_comb begin
        if (group_size_reg == '0) begin
            eff_group = GRP_W'(1);
        end else if (group_size_reg > GRP_W'(MAX_GROUP)) begin
            eff_group = GRP_W'(MAX_GROUP);
        end else begin
            eff_group = group_size_reg;
        end
    end

    // reducing pow * (index + 1) gives the same residue as using the reduced point
    assign point    = {1'b0, replica_index_reg} + POINT_W'(1);
    assign sum_val  = SUM_W'(pow_reg * byte_reg) + SUM_W'(acc_reg);
    assign prod_val = PROD_W'(pow_reg * point);
    assign pos_inc  = pos_reg + GRP_W'(1);
    assign emit     = last_reg || (pos_inc >= eff_group);

    assign cur_state = mem_vld_reg ? rd_data_reg : FOLD_STATE_RESET;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {1'b0, len_reg, word_reg};

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= state_mem[0];
        end
        if (wr_en) begin
            state_mem[0] <= wr_data;
        end
    end

    always_comb begin
        state_next         = state_reg;
        replica_index_next = replica_index_reg;
        group_size_next    = group_size_reg;
        modulus_next       = modulus_reg;
        acc_next           = acc_reg;
        pow_next           = pow_reg;
        pos_next           = pos_reg;
        cnt_next           = cnt_reg;
        byte_next          = byte_reg;
        last_next          = last_reg;
        pad_next           = pad_reg;
        num_acc_next       = num_acc_reg;
        num_pow_next       = num_pow_reg;
        rem_acc_next       = rem_acc_reg;
        rem_pow_next       = rem_pow_reg;
        step_next          = step_reg;
        m_tlast_next       = m_tlast_reg;
        word_next          = word_reg;
        len_next           = len_reg;
        mem_vld_next       = mem_vld_reg;
        m_tvalid_next      = m_tvalid_reg && !m_tready;
        rd_en              = 1'b0;
        wr_en              = 1'b0;
        wr_data            = FOLD_STATE_RESET;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_REPLICA_INDEX: replica_index_next = cfg_wdata[WORD_W-1:0];
                REG_GROUP_SIZE:    group_size_next    = cfg_wdata[GRP_W-1:0];
                REG_MODULUS:       modulus_next       = cfg_wdata[WORD_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    byte_next  = s_tdata[DATA_W-1:0];
                    last_next  = s_tlast;
                    pad_next   = 1'b0;
                    rd_en      = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                acc_next   = cur_state.group_accumulator;
                pow_next   = cur_state.current_power;
                pos_next   = cur_state.group_position;
                cnt_next   = cur_state.byte_count + LEN_W'(1);
                state_next = ST_MUL;
            end
            ST_MUL: begin
                num_acc_next = PROD_W'(sum_val);
                num_pow_next = prod_val;
                rem_acc_next = '0;
                rem_pow_next = '0;
                step_next    = '0;
                state_next   = ST_RED;
            end
            ST_RED: begin
                // both residues come out msb first, one bit a cycle
                rem_acc_next = rem_step(rem_acc_reg, num_acc_reg[PROD_W-1], eff_mod);
                rem_pow_next = rem_step(rem_pow_reg, num_pow_reg[PROD_W-1], eff_mod);
                num_acc_next = {num_acc_reg[PROD_W-2:0], 1'b0};
                num_pow_next = {num_pow_reg[PROD_W-2:0], 1'b0};
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(RED_STEPS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (last_reg && (pos_inc < eff_group)) begin
                    // short final group: fold another pad byte
                    acc_next   = rem_acc_reg;
                    pow_next   = rem_pow_reg;
                    pos_next   = pos_inc;
                    byte_next  = PAD_BYTE;
                    pad_next   = 1'b1;
                    state_next = ST_MUL;
                end else if (!emit) begin
                    wr_en                     = 1'b1;
                    wr_data.group_accumulator = rem_acc_reg;
                    wr_data.current_power     = rem_pow_reg;
                    wr_data.group_position    = pos_inc;
                    wr_data.byte_count        = cnt_reg;
                    mem_vld_next              = 1'b1;
                    state_next                = ST_IDLE;
                end else if (!m_tvalid_reg || m_tready) begin
                    wr_en              = 1'b1;
                    wr_data            = FOLD_STATE_RESET;
                    wr_data.byte_count = last_reg ? '0 : cnt_reg;
                    mem_vld_next       = 1'b1;
                    m_tvalid_next      = 1'b1;
                    m_tlast_next       = last_reg;
                    word_next          = rem_acc_reg;
                    len_next           = last_reg ? cnt_reg : '0;
                    state_next         = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            replica_index_reg <= RST_REPLICA_INDEX;
            group_size_reg    <= RST_GROUP_SIZE;
            modulus_reg       <= RST_MODULUS;
            mem_vld_reg       <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg         <= state_next;
            replica_index_reg <= replica_index_next;
            group_size_reg    <= group_size_next;
            modulus_reg       <= modulus_next;
            mem_vld_reg       <= mem_vld_next;
            m_tvalid_reg      <= m_tvalid_next;
        end
        acc_reg     <= acc_next;
        pow_reg     <= pow_next;
        pos_reg     <= pos_next;
        cnt_reg     <= cnt_next;
        byte_reg    <= byte_next;
        last_reg    <= last_next;
        pad_reg     <= pad_next;
        num_acc_reg <= num_acc_next;
        num_pow_reg <= num_pow_next;
        rem_acc_reg <= rem_acc_next;
        rem_pow_reg <= rem_pow_next;
        step_reg    <= step_next;
        m_tlast_reg <= m_tlast_next;
        word_reg    <= word_next;
        len_reg     <= len_next;
    end

    `VCF_ASSERT_IMP(a_rem_below_mod, state_reg == ST_RED, (rem_acc_reg < eff_mod) && (rem_pow_reg < eff_mod), "remainder reached the modulus")
    `VCF_ASSERT_IMP(a_pad_only_last, (state_reg == ST_MUL) && pad_reg, last_reg, "padding outside the final group")
    `VCF_ASSERT_IMP(a_len_only_final, m_tvalid && !m_tlast, m_tdata[46:15] == '0, "length on a non-final word")
    `VCF_ASSERT_NXT(a_request_reads, s_tvalid && s_tready, state_reg == ST_READ, "request taken without a state read")

endmodule

`default_nettype wire

### dv/vandermonde_coded_fragment_unit_tb.sv
// self-checking bench for the coded fragment unit: byte requests in, coded words out
// predicts each coded word from its own copy of registers and group state
// depends on vcf_pkg and the vandermonde_coded_fragment_unit rtl
`timescale 1ns / 1ps

module vandermonde_coded_fragment_unit_tb;
    import vcf_pkg::*;

    localparam int unsigned RANDOM_ITEMS   = 1650;
    localparam int unsigned SETTLE_CYCLES  = 80;
    localparam int unsigned LONG_HOLD      = 600;
    localparam int unsigned WATCHDOG_LIMIT = 40000;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic              last;
    } msg_byte_t;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              fin;
        logic [LEN_W-1:0]  len;
    } coded_word_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;

    msg_byte_t   pending_bytes[$];
    coded_word_t expected_words[$];

    // register copies and group state of the predictor
    int unsigned      cur_replica = 0;
    int unsigned      cur_group   = 1;
    int unsigned      cur_modulus = 257;
    int unsigned      grp_acc     = 0;
    int unsigned      grp_pos     = 0;
    int unsigned      grp_pow     = 1;
    logic [LEN_W-1:0] msg_len     = '0;

    int unsigned src_wait     = 0;
    int unsigned sink_wait    = 0;
    bit          src_gaps_on  = 1'b1;
    bit          sink_gaps_on = 1'b1;
    int unsigned words_seen   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned mismatches   = 0;

    vandermonde_coded_fragment_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] data_byte
        .s_tlast   (s_tlast),   // end_of_message
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [14:0] coded_word, [46:15] unpadded_len
        .m_tlast   (m_tlast)    // final_word
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 16);
        return $urandom_range(30, 120);
    endfunction

    function automatic int unsigned eff_group(input int unsigned g);
        if (g == 0) return 1;
        if (g > MAX_GROUP) return MAX_GROUP;
        return g;
    endfunction

    function automatic void fold_into_group(input int unsigned b);
        int unsigned m;
        int unsigned pt;
        m = (cur_modulus == 0) ? 1 : cur_modulus;
        pt = (cur_replica + 1) % m;
        grp_acc = (grp_acc + grp_pow * b) % m;
        grp_pow = (grp_pow * pt) % m;
        grp_pos++;
    endfunction

    function automatic void predict_coded_word(input logic [DATA_W-1:0] data,
                                               input logic last);
        int unsigned g;
        coded_word_t w;
        g = eff_group(cur_group);
        msg_len = msg_len + 1'b1;
        fold_into_group(data);
        if (last) begin
            // short group is filled out with ascii zeros
            while (grp_pos < g) fold_into_group(PAD_BYTE);
            w.word = grp_acc[WORD_W-1:0];
            w.fin  = 1'b1;
            w.len  = msg_len;
        end else if (grp_pos >= g) begin
            w.word = grp_acc[WORD_W-1:0];
            w.fin  = 1'b0;
            w.len  = '0;
        end else begin
            return;
        end
        expected_words = {expected_words, w};
        grp_acc = 0;
        grp_pos = 0;
        grp_pow = 1;
        if (last) msg_len = '0;
    endfunction

    // byte request driver
    always @(posedge aclk) begin : byte_driver
        msg_byte_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_wait = 0;
        end else begin
            if (s_tvalid && s_tready) predict_coded_word(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (src_wait > 0) begin
                    src_wait--;
                    s_tvalid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    nxt = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tlast  <= nxt.last;
                    if (src_gaps_on) src_wait = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // coded word monitor and receiver back-pressure
    always @(posedge aclk) begin : word_monitor
        coded_word_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    $error("coded word %0d arrived with no request to account for it",
                           m_tdata[WORD_W-1:0]);
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_tdata[WORD_W-1:0] !== want.word) begin
                        $error("coded_word: expected %0d, got %0d",
                               want.word, m_tdata[WORD_W-1:0]);
                        mismatches++;
                    end
                    if (m_tlast !== want.fin) begin
                        $error("final_word: expected %0d, got %0d", want.fin, m_tlast);
                        mismatches++;
                    end
                    if (m_tdata[WORD_W +: LEN_W] !== want.len) begin
                        $error("unpadded_len: expected %0d, got %0d",
                               want.len, m_tdata[WORD_W +: LEN_W]);
                        mismatches++;
                    end
                end
                words_seen++;
                // long hold so the unit backs up and stalls its input
                if (words_seen == 150 || words_seen == 700) sink_wait = LONG_HOLD;
            end
            if (sink_wait > 0) begin
                m_tready <= 1'b0;
                sink_wait--;
            end else begin
                m_tready <= 1'b1;
                if (sink_gaps_on) sink_wait = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("vandermonde_coded_fragment_unit test failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_REPLICA_INDEX: cur_replica = val[WORD_W-1:0];
            REG_GROUP_SIZE:    cur_group   = val[GRP_W-1:0];
            REG_MODULUS:       cur_modulus = val[WORD_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_byte(input logic [DATA_W-1:0] data, input logic last);
        msg_byte_t mb;
        mb.data = data;
        mb.last = last;
        pending_bytes = {pending_bytes, mb};
    endtask

    task automatic queue_message(input int unsigned len, input bit close);
        msg_byte_t mb;
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0)
                mb.data = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
                mb.data = 8'($urandom);
            mb.last = close && (i == len - 1);
            pending_bytes = {pending_bytes, mb};
        end
    endtask

    // all requests taken, all words back, then time for a silent byte to finish
    task automatic drain();
        do @(negedge aclk);
        while (pending_bytes.size() != 0 || s_tvalid || expected_words.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        int unsigned sent;
        int unsigned sel;
        int unsigned g;
        int unsigned eg;
        int unsigned m;
        int unsigned r;
        int unsigned n_msgs;
        int unsigned len;
        bit          close;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reset settings: point 1, one byte per word
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hAA, 1'b0);
        queue_byte(8'h55, 1'b1);
        drain();

        // full group, then a short group that gets padded, then an exact fit
        write_reg(REG_REPLICA_INDEX, 15'd2);
        write_reg(REG_GROUP_SIZE, 15'd4);
        write_reg(REG_MODULUS, 15'h7FFF);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hC8, 1'b0);
        queue_byte(8'h07, 1'b1);
        repeat (3) queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b1);
        drain();

        // group size zero and modulus zero, upper wdata bits ignored
        write_reg(REG_GROUP_SIZE, 15'h7E00);
        write_reg(REG_MODULUS, 15'd0);
        queue_byte(8'h3C, 1'b0);
        queue_byte(8'hC3, 1'b1);
        drain();

        // modulus one, oversize group saturates, top replica index
        write_reg(REG_MODULUS, 15'd1);
        write_reg(REG_GROUP_SIZE, 15'd511);
        write_reg(REG_REPLICA_INDEX, 15'h7FFF);
        queue_byte(8'h81, 1'b1);
        drain();

        // group size and modulus lowered part way through a group
        write_reg(REG_REPLICA_INDEX, 15'd1);
        write_reg(REG_GROUP_SIZE, 15'd8);
        write_reg(REG_MODULUS, 15'd257);
        repeat (5) queue_byte(8'($urandom), 1'b0);
        drain();
        write_reg(REG_GROUP_SIZE, 15'd3);
        write_reg(REG_MODULUS, 15'd2);
        queue_byte(8'h9E, 1'b0);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'hF0, 1'b1);
        drain();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 4)       g = $urandom_range(256, 511);
            else if (sel < 8)  g = $urandom_range(64, 255);
            else if (sel < 11) g = 0;
            else if (sel < 30) g = $urandom_range(17, 63);
            else               g = $urandom_range(1, 16);

            sel = $urandom_range(0, 99);
            if (sel < 3)       m = 0;
            else if (sel < 6)  m = 1;
            else if (sel < 15) m = 2;
            else if (sel < 30) m = 32767;
            else if (sel < 40) m = 257;
            else               m = $urandom_range(2, 32767);

            sel = $urandom_range(0, 99);
            if (sel < 15)      r = 0;
            else if (sel < 30) r = 32767;
            else if (sel < 35) r = (m > 1) ? m - 1 : 0;
            else               r = $urandom_range(0, 32767);

            write_reg(REG_REPLICA_INDEX, 15'(r));
            write_reg(REG_GROUP_SIZE, {6'($urandom), 9'(g)});
            write_reg(REG_MODULUS, 15'(m));
            src_gaps_on  = ($urandom_range(0, 3) != 0);
            sink_gaps_on = ($urandom_range(0, 3) != 0);

            eg = eff_group(g);
            n_msgs = (eg >= 64) ? $urandom_range(1, 2) : $urandom_range(2, 6);
            for (int unsigned k = 0; k < n_msgs; k++) begin
                len = (eg >= 64) ? $urandom_range(1, eg + 8) : $urandom_range(1, 3 * eg + 1);
                // sometimes leave the last message open across a register change
                close = (k != n_msgs - 1) || ($urandom_range(0, 3) != 0);
                queue_message(len, close);
                sent += len;
            end
            drain();
        end

        // close any message left open
        queue_byte(8'($urandom), 1'b1);
        drain();

        if (mismatches == 0)
            $display("vandermonde_coded_fragment_unit test passed");
        else
            $display("vandermonde_coded_fragment_unit test failed");
        $finish;
    end

endmodule
